### rtl/fvcc_pkg.sv
// types, constants and color wheel tables of the flow vector color coder
package fvcc_pkg;

   localparam int FLOW_W = 16;
   localparam int STEPS  = 16;

   localparam logic CMD_MEASURE = 1'b0;
   localparam logic CMD_COLOR   = 1'b1;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef struct packed {
      logic              command;
      logic              frame_start;
      logic signed [FLOW_W-1:0] flow_x;
      logic signed [FLOW_W-1:0] flow_y;
      logic              flow_unknown;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   // atan(2^-i) in units of 2^-16 turn
   function automatic logic [15:0] cordic_turn(input logic [3:0] i);
      logic [15:0] t;
      case (i)
         4'd0:  t = 16'd8192;
         4'd1:  t = 16'd4836;
         4'd2:  t = 16'd2555;
         4'd3:  t = 16'd1297;
         4'd4:  t = 16'd651;
         4'd5:  t = 16'd326;
         4'd6:  t = 16'd163;
         4'd7:  t = 16'd81;
         4'd8:  t = 16'd41;
         4'd9:  t = 16'd20;
         4'd10: t = 16'd10;
         4'd11: t = 16'd5;
         4'd12: t = 16'd3;
         4'd13: t = 16'd1;
         4'd14: t = 16'd1;
         default: t = 16'd0;
      endcase
      return t;
   endfunction

   // 255*i/6
   function automatic logic [7:0] seg6(input logic [5:0] i);
      logic [7:0] v;
      case (i)
         6'd0: v = 8'd0;
         6'd1: v = 8'd42;
         6'd2: v = 8'd85;
         6'd3: v = 8'd127;
         6'd4: v = 8'd170;
         6'd5: v = 8'd212;
         default: v = 8'd0;
      endcase
      return v;
   endfunction

   // 255*i/4
   function automatic logic [7:0] seg4(input logic [5:0] i);
      logic [7:0] v;
      case (i)
         6'd0: v = 8'd0;
         6'd1: v = 8'd63;
         6'd2: v = 8'd127;
         6'd3: v = 8'd191;
         default: v = 8'd0;
      endcase
      return v;
   endfunction

   // 255*i/11
   function automatic logic [7:0] seg11(input logic [5:0] i);
      logic [7:0] v;
      case (i)
         6'd0:  v = 8'd0;
         6'd1:  v = 8'd23;
         6'd2:  v = 8'd46;
         6'd3:  v = 8'd69;
         6'd4:  v = 8'd92;
         6'd5:  v = 8'd115;
         6'd6:  v = 8'd139;
         6'd7:  v = 8'd162;
         6'd8:  v = 8'd185;
         6'd9:  v = 8'd208;
         6'd10: v = 8'd231;
         default: v = 8'd0;
      endcase
      return v;
   endfunction

   // 255*i/13
   function automatic logic [7:0] seg13(input logic [5:0] i);
      logic [7:0] v;
      case (i)
         6'd0:  v = 8'd0;
         6'd1:  v = 8'd19;
         6'd2:  v = 8'd39;
         6'd3:  v = 8'd58;
         6'd4:  v = 8'd78;
         6'd5:  v = 8'd98;
         6'd6:  v = 8'd117;
         6'd7:  v = 8'd137;
         6'd8:  v = 8'd156;
         6'd9:  v = 8'd176;
         6'd10: v = 8'd196;
         6'd11: v = 8'd215;
         6'd12: v = 8'd235;
         default: v = 8'd0;
      endcase
      return v;
   endfunction

   // one channel of color wheel entry k
   function automatic logic [7:0] wheel(input logic [5:0] k, input logic [1:0] ch);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] v;
      if (k < 6'd15) begin
         r = 8'd255; g = 8'(k) * 8'd17; b = 8'd0;
      end else if (k < 6'd21) begin
         r = 8'd255 - seg6(k - 6'd15); g = 8'd255; b = 8'd0;
      end else if (k < 6'd25) begin
         r = 8'd0; g = 8'd255; b = seg4(k - 6'd21);
      end else if (k < 6'd36) begin
         r = 8'd0; g = 8'd255 - seg11(k - 6'd25); b = 8'd255;
      end else if (k < 6'd49) begin
         r = seg13(k - 6'd36); g = 8'd0; b = 8'd255;
      end else begin
         r = 8'd255; g = 8'd0; b = 8'd255 - seg6((k < 6'd55) ? k - 6'd49 : 6'd0);
      end
      case (ch)
         CH_RED:   v = r;
         CH_GREEN: v = g;
         default:  v = b;
      endcase
      return v;
   endfunction

endpackage

### rtl/flow_vector_color_coder.sv
// flow vector color coder: iterative radius, angle and wheel blend sequencer
// A measure word first squares the components in ST_SQX and ST_SQY, then ST_ROOT runs the
// bit-serial square root and the 16-step angle CORDIC side by side. A color word runs the
// same front part, places the angle on the wheel in ST_POS, then per channel passes ST_BLEND,
// ST_MUL and the restoring divider in ST_DIV (skipped for a radius beyond the maximum),
// and hands the word to the output register in ST_DONE. Unknown color words and color
// words seen while the stored maximum is zero go to ST_DONE with black, and an unknown
// measure word is finished in the cycle it is accepted. The next word is taken as soon
// as the sequencer is idle, even while the previous color still waits in the output
// register. frame_start clears the stored maximum radius when its measure word is taken.
module flow_vector_color_coder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fvcc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fvcc_pkg::rsp_type rsp_data
);
   import fvcc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQX, ST_SQY, ST_ROOT, ST_POS, ST_BLEND, ST_MUL, ST_DIV, ST_DONE
   } state_type;

   localparam int CW = 60;  // cordic datapath width
   localparam int NW = 42;  // divider remainder width
   localparam int CS = 56 - FLOW_W;  // cordic input scaling

   state_type          state_ff, state_in;
   logic               cmd_ff, cmd_in;
   logic signed [FLOW_W-1:0] fx_ff, fx_in, fy_ff, fy_in;
   logic [16:0]        max_ff, max_in;
   logic [31:0]        rv_ff, rv_in;      // root remainder
   logic [31:0]        res_ff, res_in;    // root result
   logic signed [CW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [15:0]        acc_ff, acc_in;    // angle, 2^-16 turn
   logic [3:0]         step_ff, step_in;
   logic [5:0]         k0_ff, k0_in;
   logic [15:0]        f_ff, f_in;
   logic [1:0]         ch_ff, ch_in;
   logic [23:0]        c_ff, c_in;
   logic [NW-1:0]      rem_ff, rem_in;
   logic [7:0]         q_ff, q_in;
   logic [2:0]         bitc_ff, bitc_in;
   logic [7:0]         rgb_ff [3];
   logic [7:0]         rgb_in [3];
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // combinational helpers
   logic [15:0]        ax, ay;
   logic [31:0]        root_bit, root_trial;
   logic signed [CW-1:0] xs, ys;
   logic [21:0]        pos;
   logic [24:0]        blend;
   logic [NW-1:0]      den_sh;
   logic [NW-1:0]      rem_next;
   logic [7:0]         q_next;
   logic [8:0]         q_ceil;
   logic               in_range;
   logic [25:0]        dim;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      ax = fx_ff[FLOW_W-1] ? 16'(-fx_ff) : 16'(fx_ff);
      ay = fy_ff[FLOW_W-1] ? 16'(-fy_ff) : 16'(fy_ff);
      root_bit   = 32'h4000_0000 >> {step_ff, 1'b0};
      root_trial = res_ff + root_bit;
      xs = cx_ff >>> step_ff;
      ys = cy_ff >>> step_ff;
      pos   = 22'(acc_ff) * 22'd54;
      blend = (25'h10000 - 25'(f_ff)) * 25'(wheel(k0_ff, ch_ff))
            + 25'(f_ff) * 25'(wheel(k0_ff + 6'd1, ch_ff));
      in_range = (res_ff[16:0] <= max_ff);
      dim      = 26'(c_ff) * 26'd3;
      den_sh   = NW'({max_ff, 16'h0000}) << bitc_ff;
      rem_next = rem_ff;
      q_next   = q_ff;
      if (rem_ff >= den_sh) begin
         rem_next = rem_ff - den_sh;
         q_next[bitc_ff] = 1'b1;
      end
      q_ceil = {1'b0, q_next} + 9'(rem_next != '0);
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      max_in       = max_ff;
      rv_in        = rv_ff;
      res_in       = res_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      acc_in       = acc_ff;
      step_in      = step_ff;
      k0_in        = k0_ff;
      f_in         = f_ff;
      ch_in        = ch_ff;
      c_in         = c_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      bitc_in      = bitc_ff;
      rgb_in       = rgb_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in  = req_data.command;
               fx_in   = req_data.flow_x;
               fy_in   = req_data.flow_y;
               step_in = '0;
               // mirror left half-plane vectors, start angle at half a turn
               if (req_data.flow_x[FLOW_W-1]) begin
                  cx_in  = -(CW'($signed(req_data.flow_x)) <<< CS);
                  cy_in  = -(CW'($signed(req_data.flow_y)) <<< CS);
                  acc_in = 16'h8000;
               end else begin
                  cx_in  = CW'($signed(req_data.flow_x)) <<< CS;
                  cy_in  = CW'($signed(req_data.flow_y)) <<< CS;
                  acc_in = 16'h0000;
               end
               if (req_data.command == CMD_MEASURE) begin
                  if (req_data.frame_start) begin
                     max_in = '0;
                  end
                  state_in = req_data.flow_unknown ? ST_IDLE : ST_SQX;
               end else if (req_data.flow_unknown || max_ff == '0) begin
                  rgb_in[0] = '0;
                  rgb_in[1] = '0;
                  rgb_in[2] = '0;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_SQX;
               end
            end
         end
         ST_SQX: begin
            rv_in    = 32'(ax) * 32'(ax);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            rv_in    = rv_ff + 32'(ay) * 32'(ay);
            res_in   = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            // one root bit and one cordic rotation per cycle
            if (rv_ff >= root_trial) begin
               rv_in  = rv_ff - root_trial;
               res_in = (res_ff >> 1) + root_bit;
            end else begin
               res_in = res_ff >> 1;
            end
            if (!cy_ff[CW-1]) begin
               cx_in  = cx_ff + ys;
               cy_in  = cy_ff - xs;
               acc_in = acc_ff + cordic_turn(step_ff);
            end else begin
               cx_in  = cx_ff - ys;
               cy_in  = cy_ff + xs;
               acc_in = acc_ff - cordic_turn(step_ff);
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(STEPS - 1)) begin
               if (cmd_ff == CMD_MEASURE) begin
                  if (res_in[16:0] > max_ff) begin
                     max_in = res_in[16:0];
                  end
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_POS;
               end
            end
         end
         ST_POS: begin
            k0_in    = pos[21:16];
            f_in     = pos[15:0];
            ch_in    = CH_RED;
            state_in = ST_BLEND;
         end
         ST_BLEND: begin
            c_in     = blend[23:0];
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (in_range) begin
               rem_in   = NW'(res_ff[16:0]) * NW'(24'hFF0000 - c_ff);
               q_in     = '0;
               bitc_in  = 3'd7;
               state_in = ST_DIV;
            end else begin
               rgb_in[ch_ff] = dim[25:18];
               ch_in    = ch_ff + 2'd1;
               state_in = (ch_ff == CH_BLUE) ? ST_DONE : ST_BLEND;
            end
         end
         ST_DIV: begin
            rem_in  = rem_next;
            q_in    = q_next;
            bitc_in = bitc_ff - 3'd1;
            if (bitc_ff == 3'd0) begin
               rgb_in[ch_ff] = (q_ceil >= 9'd255) ? 8'd0 : 8'(9'd255 - q_ceil);
               ch_in    = ch_ff + 2'd1;
               state_in = (ch_ff == CH_BLUE) ? ST_DONE : ST_BLEND;
            end
         end
         ST_DONE: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_data_in.red   = rgb_ff[0];
               rsp_data_in.green = rgb_ff[1];
               rsp_data_in.blue  = rgb_ff[2];
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
      cmd_ff      <= cmd_in;
      fx_ff       <= fx_in;
      fy_ff       <= fy_in;
      rv_ff       <= rv_in;
      res_ff      <= res_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      acc_ff      <= acc_in;
      k0_ff       <= k0_in;
      f_ff        <= f_in;
      ch_ff       <= ch_in;
      c_ff        <= c_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      bitc_ff     <= bitc_in;
      rgb_ff      <= rgb_in;
      rsp_data_ff <= rsp_data_in;
   end

   // wheel position stays inside the table
   a_k0_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BLEND |-> k0_ff <= 6'd53)
      else $error("wheel index out of range");

   // an in-range quotient never exceeds full scale
   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && bitc_ff == 3'd0) |-> q_ceil <= 9'd255)
      else $error("ratio quotient above full scale");

   // a result is only loaded from the done state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result loaded outside done state");

   // root and angle loop does not leave before its sixteenth step
   a_root_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT && step_ff != 4'(STEPS - 1)) |=> state_ff == ST_ROOT)
      else $error("root loop left early");

endmodule
